// File: rtl/interval_overlap_clusterer_assert.svh
// assertion macros used by the checker file
`ifndef INTERVAL_OVERLAP_CLUSTERER_ASSERT_SVH
`define INTERVAL_OVERLAP_CLUSTERER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define IOC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("interval clusterer check failed");

// next-cycle implication, disabled while reset is held
`define IOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("interval clusterer check failed");

`endif

// File: rtl/ioc_pkg.sv
package ioc_pkg;

	localparam int MAX_CLUSTERS_DEF = 256;
	localparam int BOUND_W          = 42;
	localparam int IDX_OUT_W        = 8;
	localparam int MARGIN_W         = 8;
	localparam int SCALED_W         = 40;

	// saturating hit tally carried along the chain
	localparam logic [1:0] HITS_NONE = 2'd0;
	localparam logic [1:0] HITS_ONE  = 2'd1;
	localparam logic [1:0] HITS_MANY = 2'd2;

	typedef logic [MARGIN_W-1:0] margin_t;

	typedef struct packed {
		logic [31:0] point_id;
		logic [23:0] degree;
		logic [31:0] mean_inv_visit;
		logic [31:0] center;
		logic [31:0] half_width;
	} in_beat_t;

	typedef struct packed {
		logic [31:0]          out_point_id;
		logic [23:0]          out_degree;
		logic [IDX_OUT_W-1:0] cluster_index;
		logic [31:0]          out_mean_inv_visit;
		logic [31:0]          out_center;
		logic [SCALED_W-1:0]  scaled_half_width;
		logic                 is_new;
		logic                 table_full;
	} out_beat_t;

	// probe that walks the cell chain; bounds are two's complement
	typedef struct packed {
		logic                 valid;
		logic [1:0]           hits;
		logic [IDX_OUT_W-1:0] hit_idx;
		logic [BOUND_W-1:0]   lo;
		logic [BOUND_W-1:0]   hi;
	} probe_t;

	// new cluster write, lands in the cell at the current count
	typedef struct packed {
		logic               en;
		logic [BOUND_W-1:0] lo;
		logic [BOUND_W-1:0] hi;
	} wr_t;

endpackage

// File: rtl/ioc_chan_if.sv
interface ioc_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ioc_cell.sv
module ioc_cell import ioc_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CNT_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  probe_t           probe_in,
	input  wr_t              wr,
	input  logic [CNT_W-1:0] count,
	output probe_t           probe_out
);

	logic [BOUND_W-1:0] lo_q;
	logic [BOUND_W-1:0] hi_q;
	logic               in_use;
	logic               hit;
	probe_t             nxt;

	// stored bounds of this slot
	always_ff @(posedge clk) begin
		if (wr.en && count == CNT_W'(INDEX)) begin
			lo_q <= wr.lo;
			hi_q <= wr.hi;
		end
	end

	// closed-interval overlap against the passing probe
	always_comb begin
		in_use = CNT_W'(INDEX) < count;
		hit    = probe_in.valid && in_use
			&& ($signed(probe_in.lo) <= $signed(hi_q))
			&& ($signed(lo_q) <= $signed(probe_in.hi));
		nxt = probe_in;
		if (hit) begin
			nxt.hits    = (probe_in.hits == HITS_NONE) ? HITS_ONE : HITS_MANY;
			nxt.hit_idx = IDX_OUT_W'(INDEX);
		end
	end

	// hand the probe to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_out <= '0;
		end else begin
			probe_out <= nxt;
		end
	end

endmodule

// File: rtl/interval_overlap_clusterer.sv
// Interval overlap clusterer. Points are taken one at a time: a point is accepted, its
// half-width is scaled by the margin register, and the resulting closed interval walks a
// chain of MAX_CLUSTERS compare cells, one cell per cycle, each holding one stored cluster.
// After acceptance a point passes through the multiply, form, walk and decide states before
// the next point can be taken. The result goes to an output register, but while an earlier
// result still waits there the decide state holds. A point that overlaps several clusters
// gives no result. Slots beyond the cluster count are never compared, so the cells need no
// clearing after reset. The margin register resets to 1 and may be written while idle.
module interval_overlap_clusterer import ioc_pkg::*; #(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ioc_chan_if.sink   in_ch,
	ioc_chan_if.source out_ch,
	ioc_chan_if.sink   cfg_ch
);

	localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL    = 5'b00010,
		ST_FORM   = 5'b00100,
		ST_WALK   = 5'b01000,
		ST_DECIDE = 5'b10000
	} state_t;

	state_t               state_q;
	margin_t              margin_q;
	logic [CNT_W-1:0]     count_q;
	in_beat_t             pt_q;
	logic [SCALED_W-1:0]  scaled_q;
	logic [1:0]           hits_q;
	logic [IDX_OUT_W-1:0] hit_idx_q;
	logic [BOUND_W-1:0]   lo_q;
	logic [BOUND_W-1:0]   hi_q;
	logic                 out_valid_q;
	out_beat_t            out_q;

	logic               out_free;
	logic               full;
	logic               emit;
	logic [BOUND_W-1:0] lo_form;
	logic [BOUND_W-1:0] hi_form;
	probe_t             chain [MAX_CLUSTERS+1];
	wr_t                wr;

	// configuration port, always ready
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= margin_t'(1);
		end else if (cfg_ch.valid) begin
			margin_q <= cfg_ch.data;
		end
	end

	// handshake and decision
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_free     = !out_valid_q || out_ch.ready;
	assign full         = (count_q == CNT_W'(MAX_CLUSTERS));
	assign emit         = (state_q == ST_DECIDE) && out_free && (hits_q != HITS_MANY);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// interval bounds, 42-bit two's complement
	assign lo_form = {10'd0, pt_q.center} - {2'd0, scaled_q};
	assign hi_form = {10'd0, pt_q.center} + {2'd0, scaled_q};

	// probe injected at the head of the chain
	always_comb begin
		chain[0].valid   = (state_q == ST_FORM);
		chain[0].hits    = HITS_NONE;
		chain[0].hit_idx = '0;
		chain[0].lo      = lo_form;
		chain[0].hi      = hi_form;
	end

	// new cluster write
	always_comb begin
		wr.en = emit && (hits_q == HITS_NONE) && !full;
		wr.lo = lo_q;
		wr.hi = hi_q;
	end

	// compare cells
	for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
		ioc_cell #(
			.INDEX (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_in  (chain[g]),
			.wr        (wr),
			.count     (count_q),
			.probe_out (chain[g+1])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_FORM;
				end
				ST_FORM: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (chain[MAX_CLUSTERS].valid) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (hits_q == HITS_MANY || out_free) state_q <= ST_IDLE;
					if (wr.en) count_q <= count_q + CNT_W'(1);
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// point payload, scaling and chain result
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) pt_q <= in_ch.data;
		if (state_q == ST_MUL) begin
			scaled_q <= {8'd0, pt_q.half_width} * {32'd0, margin_q};
		end
		if (state_q == ST_FORM) begin
			lo_q <= lo_form;
			hi_q <= hi_form;
		end
		if (state_q == ST_WALK && chain[MAX_CLUSTERS].valid) begin
			hits_q    <= chain[MAX_CLUSTERS].hits;
			hit_idx_q <= chain[MAX_CLUSTERS].hit_idx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_point_id       <= pt_q.point_id;
			out_q.out_degree         <= pt_q.degree;
			out_q.out_mean_inv_visit <= pt_q.mean_inv_visit;
			out_q.out_center         <= pt_q.center;
			out_q.scaled_half_width  <= scaled_q;
			priority if (hits_q == HITS_ONE) begin
				out_q.cluster_index <= hit_idx_q;
				out_q.is_new        <= 1'b0;
				out_q.table_full    <= 1'b0;
			end else if (!full) begin
				out_q.cluster_index <= IDX_OUT_W'(count_q);
				out_q.is_new        <= 1'b1;
				out_q.table_full    <= 1'b0;
			end else begin
				out_q.cluster_index <= '0;
				out_q.is_new        <= 1'b0;
				out_q.table_full    <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/ioc_checker.sv
`include "interval_overlap_clusterer_assert.svh"

module ioc_checker import ioc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);

	// a stalled result beat holds
	`IOC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// new and full never together
	`IOC_ASSERT_NOW(a_flags_excl, clk, arst_n, out_valid, !(out_data.is_new && out_data.table_full))

	// a full-table beat carries index zero
	`IOC_ASSERT_NOW(a_full_idx, clk, arst_n, out_valid && out_data.table_full, out_data.cluster_index == '0)

	// one point at a time: busy right after taking a beat
	`IOC_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind interval_overlap_clusterer ioc_checker u_ioc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
